// ===== hw/rtl/blm_pkg.sv =====
// Shared constants, types and the threshold ladder for the battery level monitor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package blm_pkg;

    localparam int unsigned ADC_W   = 10;
    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned RUN_W   = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned STEPS   = 10;

    // Register indexes, taken from paddr[2]
    localparam logic REG_SHUTDOWN_LEVEL = 1'b0;
    localparam logic REG_CONFIRM_COUNT  = 1'b1;

    localparam logic [LEVEL_W-1:0] SHUTDOWN_LEVEL_RST = 7'd10;
    localparam logic [RUN_W-1:0]   CONFIRM_COUNT_RST  = 4'd5;

    // Filter: (old*9 + step)/10, divide done as *6554 >> 16 (exact for this range)
    localparam int unsigned SUM_W  = 11;
    localparam int unsigned RECIP_W = 13;
    localparam int unsigned PROD_W = SUM_W + RECIP_W;
    localparam int unsigned RECIP_SHIFT = 16;
    localparam logic [SUM_W-1:0]   FILT_OLD_WEIGHT = 11'd9;
    localparam logic [RECIP_W-1:0] RECIP_TEN       = 13'd6554;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_STEP = 7'd10;

    typedef logic [ADC_W-1:0] t_bound_arr [STEPS];

    localparam t_bound_arr LADDER_BOUNDS = '{
        10'd809, 10'd791, 10'd779, 10'd767, 10'd759,
        10'd753, 10'd749, 10'd741, 10'd728, 10'd635
    };

    // Highest rung whose bound the sample exceeds; 0 when it exceeds none of them.
    function automatic logic [LEVEL_W-1:0] ladder_step(input logic [ADC_W-1:0] sample);
        logic [LEVEL_W-1:0] lvl;
        lvl = '0;
        for (int i = STEPS - 1; i >= 0; i--) begin
            if (sample > LADDER_BOUNDS[i]) begin
                lvl = LEVEL_MAX - LEVEL_STEP * LEVEL_W'(i);
            end
        end
        return lvl;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/battery_level_monitor_unit.sv =====
// Battery level monitor: threshold ladder, low-pass filter and shutdown confirm.
// Uses blm_pkg for the ladder, filter constants and register indexes.
// A result is registered and valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless a result is held by i_out_stall, which raises
// o_in_stall; the filter and run count update at accept; the result holds while stalled.
// Reset (synchronous, active low): registers to 10 / 5, filter empty, run count zero.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_monitor_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [blm_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [blm_pkg::DATA_W-1:0]    pwdata,
    output logic      [blm_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,

    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [blm_pkg::ADC_W-1:0]     i_adc_sample,

    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [blm_pkg::LEVEL_W-1:0]   o_step_level,
    output logic      [blm_pkg::LEVEL_W-1:0]   o_filtered_level,
    output logic                               o_shutdown_request
);
    import blm_pkg::*;

    logic [LEVEL_W-1:0] r_shutdown_level;
    logic [RUN_W-1:0]   r_confirm_count;
    logic [LEVEL_W-1:0] r_filt;
    logic               r_have_value;
    logic [RUN_W-1:0]   r_low_run;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_step_out;
    logic [LEVEL_W-1:0] r_filt_out;
    logic               r_req_out;

    logic               w_cfg_wr;
    logic               w_in_acc;
    logic [LEVEL_W-1:0] w_step;
    logic [SUM_W-1:0]   w_sum;
    logic [PROD_W-1:0]  w_prod;
    logic [LEVEL_W-1:0] n_filt;
    logic [RUN_W-1:0]   w_run_inc;
    logic [RUN_W-1:0]   n_low_run;
    logic               n_req;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_SHUTDOWN_LEVEL: prdata = DATA_W'(r_shutdown_level);
            REG_CONFIRM_COUNT:  prdata = DATA_W'(r_confirm_count);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shutdown_level <= SHUTDOWN_LEVEL_RST;
            r_confirm_count  <= CONFIRM_COUNT_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_SHUTDOWN_LEVEL: r_shutdown_level <= pwdata[LEVEL_W-1:0];
                REG_CONFIRM_COUNT:  r_confirm_count  <= pwdata[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- datapath ----------------
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_step = ladder_step(i_adc_sample);
    assign w_sum  = SUM_W'(r_filt) * FILT_OLD_WEIGHT + SUM_W'(w_step);
    assign w_prod = PROD_W'(w_sum) * PROD_W'(RECIP_TEN);

    always_comb begin
        if (r_have_value) begin
            n_filt = w_prod[RECIP_SHIFT +: LEVEL_W];
        end else begin
            n_filt = w_step;
        end
    end

    assign w_run_inc = r_low_run + RUN_W'(1);

    always_comb begin
        n_req     = 1'b0;
        n_low_run = '0;
        if (n_filt <= r_shutdown_level) begin
            if (w_run_inc >= r_confirm_count) begin
                n_req = 1'b1;
            end else begin
                n_low_run = w_run_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt       <= '0;
            r_have_value <= 1'b0;
            r_low_run    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_filt       <= n_filt;
                r_have_value <= 1'b1;
                r_low_run    <= n_low_run;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_step_out <= w_step;
            r_filt_out <= n_filt;
            r_req_out  <= n_req;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_step_level       = r_step_out;
    assign o_filtered_level   = r_filt_out;
    assign o_shutdown_request = r_req_out;

    // ---------------- assertions ----------------
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_out_valid)
        else $error("accepted beat produced no result");

    a_filter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filt <= LEVEL_MAX)
        else $error("filtered level above 100");

    a_req_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_req_out) |-> (r_low_run == '0))
        else $error("run count not cleared after shutdown request");

    a_no_acc_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_in_acc)
        else $error("input accepted while result held");

endmodule

`default_nettype wire
